// File: rtl/rau_pkg.sv
`timescale 1ns / 1ps
package rau_pkg;
	localparam int DataWidthDefault = 16;
	localparam int OutWidth = 33;
	localparam int QueueDepth = 2;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_DIV = 2'd2,
		OP_SIMP = 2'd3
	} op_t;
endpackage

// File: rtl/rau_if.sv
`timescale 1ns / 1ps
interface rau_in_if #(parameter int DATA_WIDTH = rau_pkg::DataWidthDefault);
	logic valid;
	logic ready;
	logic [1:0] op;
	logic signed [DATA_WIDTH-1:0] a_num;
	logic signed [DATA_WIDTH-1:0] a_den;
	logic signed [DATA_WIDTH-1:0] b_num;
	logic signed [DATA_WIDTH-1:0] b_den;
	modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
	modport sink (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
	logic valid;
	logic ready;
	logic signed [32:0] res_num;
	logic signed [32:0] res_den;
	logic status;
	modport source (output valid, res_num, res_den, status, input ready);
	modport sink (input valid, res_num, res_den, status, output ready);
endinterface

// File: rtl/rau_front.sv
`timescale 1ns / 1ps
module rau_front #(
	parameter int DATA_WIDTH = rau_pkg::DataWidthDefault
) (
	input logic clk,
	input logic arst_n,
	rau_in_if.sink in_ch,
	output logic q_valid,
	input logic q_ready,
	output rau_pkg::op_t q_op,
	output logic [4*DATA_WIDTH-1:0] q_data
);
	import rau_pkg::*;

	localparam int Dw = 4 * DATA_WIDTH;
	localparam int Aw = $clog2(QueueDepth);

	logic [Dw-1:0] mem_q [QueueDepth];
	op_t op_q [QueueDepth];
	logic [Aw-1:0] wr_q, rd_q;
	logic [Aw:0] cnt_q;
	logic push, pop;

	assign in_ch.ready = (cnt_q != (Aw+1)'(QueueDepth));
	assign push = in_ch.valid && in_ch.ready;
	assign q_valid = (cnt_q != '0);
	assign pop = q_valid && q_ready;
	assign q_op = op_q[rd_q];
	assign q_data = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= {in_ch.a_num, in_ch.a_den, in_ch.b_num, in_ch.b_den};
			op_q[wr_q] <= op_t'(in_ch.op);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == Aw'(QueueDepth-1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == Aw'(QueueDepth-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (Aw+1)'(QueueDepth)) else $error("queue overflow");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 1'b1) else $error("count slip");
`endif
endmodule

// File: rtl/rau_back.sv
`timescale 1ns / 1ps
module rau_back #(
	parameter int DATA_WIDTH = rau_pkg::DataWidthDefault
) (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_ready,
	input rau_pkg::op_t q_op,
	input logic [4*DATA_WIDTH-1:0] q_data,
	rau_out_if.source out_ch
);
	import rau_pkg::*;

	localparam int W = DATA_WIDTH;
	localparam int Cw = $clog2(W + 1);
	localparam int Pw = 2 * W;

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_SUM, ST_GCD, ST_DIV, ST_OUT
	} state_t;

	state_t state_q;
	op_t op_q;
	logic signed [W-1:0] an_q, ad_q, bn_q, bd_q;
	logic signed [Pw-1:0] p1_q, p2_q, p3_q;
	logic [W-1:0] y_q, g_q, rem_q, quo_q, dvd_q;
	logic [W-1:0] mn_q;
	logic div_phase_q;
	logic [Cw-1:0] bit_q;
	logic signed [OutWidth-1:0] num_q, den_q;
	logic status_q;

	logic [W-1:0] mag_an, mag_ad;
	logic [W:0] trial;
	logic [W-1:0] rsh;
	logic signed [Pw:0] sum_v;

	assign mag_an = an_q[W-1] ? W'(-an_q) : W'(an_q);
	assign mag_ad = ad_q[W-1] ? W'(-ad_q) : W'(ad_q);
	assign rsh = {rem_q[W-2:0], dvd_q[W-1]};
	assign trial = {rem_q[W-1], rsh} - {1'b0, (state_q == ST_GCD) ? y_q : g_q};
	assign sum_v = (op_q == OP_SUB) ? (Pw+1)'(p1_q) - (Pw+1)'(p2_q)
		: (Pw+1)'(p1_q) + (Pw+1)'(p2_q);

	assign q_ready = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.res_num = num_q;
	assign out_ch.res_den = den_q;
	assign out_ch.status = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_ADD;
			an_q <= '0;
			ad_q <= '0;
			bn_q <= '0;
			bd_q <= '0;
			p1_q <= '0;
			p2_q <= '0;
			p3_q <= '0;
			y_q <= '0;
			g_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			dvd_q <= '0;
			mn_q <= '0;
			div_phase_q <= 1'b0;
			bit_q <= '0;
			num_q <= '0;
			den_q <= '0;
			status_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						op_q <= q_op;
						{an_q, ad_q, bn_q, bd_q} <= q_data;
						state_q <= (q_op == OP_SIMP) ? ST_GCD : ST_MUL;
						div_phase_q <= 1'b0;
						bit_q <= '0;
						rem_q <= '0;
						y_q <= '0;
						status_q <= 1'b0;
					end
				end
				ST_MUL: begin
					p1_q <= Pw'(an_q) * Pw'(bd_q);
					p2_q <= (op_q == OP_DIV) ? Pw'(ad_q) * Pw'(bn_q) : Pw'(bn_q) * Pw'(ad_q);
					p3_q <= Pw'(ad_q) * Pw'(bd_q);
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (op_q == OP_DIV) begin
						num_q <= OutWidth'(p1_q);
						den_q <= OutWidth'(p2_q);
					end else begin
						num_q <= OutWidth'(sum_v);
						den_q <= OutWidth'(p3_q);
					end
					state_q <= ST_OUT;
				end
				ST_GCD: begin
					if (!div_phase_q) begin
						y_q <= mag_ad;
						mn_q <= mag_an;
						if (mag_an == '0 && mag_ad == '0) begin
							num_q <= OutWidth'(an_q);
							den_q <= OutWidth'(ad_q);
							status_q <= 1'b1;
							state_q <= ST_OUT;
						end else if (mag_ad == '0) begin
							g_q <= mag_an;
							state_q <= ST_DIV;
							dvd_q <= mag_an;
							rem_q <= '0;
							bit_q <= '0;
						end else begin
							div_phase_q <= 1'b1;
							dvd_q <= mag_an;
							rem_q <= '0;
							bit_q <= '0;
						end
					end else begin
						if (bit_q != Cw'(W)) begin
							dvd_q <= {dvd_q[W-2:0], 1'b0};
							rem_q <= trial[W] ? rsh : trial[W-1:0];
							bit_q <= bit_q + 1'b1;
						end else if (rem_q == '0) begin
							g_q <= y_q;
							dvd_q <= mn_q;
							rem_q <= '0;
							bit_q <= '0;
							div_phase_q <= 1'b0;
							state_q <= ST_DIV;
						end else begin
							y_q <= rem_q;
							dvd_q <= y_q;
							rem_q <= '0;
							bit_q <= '0;
						end
					end
				end
				ST_DIV: begin
					if (bit_q != Cw'(W)) begin
						dvd_q <= {dvd_q[W-2:0], 1'b0};
						quo_q <= {quo_q[W-2:0], ~trial[W]};
						rem_q <= trial[W] ? rsh : trial[W-1:0];
						bit_q <= bit_q + 1'b1;
					end else if (!div_phase_q) begin
						div_phase_q <= 1'b1;
						num_q <= an_q[W-1] ? -OutWidth'(quo_q) : OutWidth'(quo_q);
						dvd_q <= mag_ad;
						rem_q <= '0;
						bit_q <= '0;
					end else begin
						den_q <= ad_q[W-1] ? -OutWidth'(quo_q) : OutWidth'(quo_q);
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ch.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.res_num))
		else $error("result dropped");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_ready |-> !out_ch.valid) else $error("busy overlap");
	a_status_simp: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status |-> op_q == OP_SIMP) else $error("bad status");
`endif
endmodule

// File: rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
// channel  dir  fields
// in_ch    in   op, a_num, a_den, b_num, b_den
// out_ch   out  res_num, res_den, status
// Add, subtract, divide: an input transfer is queued, then taken by the back end
// (queue pop, multiply stage, sum stage, result held until taken).
// Simplify: S Euclid remainder steps, each a bitwise restoring divide plus a
// check, then two such divides; S <= 22 at W = 16.
// Reset clears the queue and the back-end state machine.
// A two-entry queue takes items while the back end works or its result stalls.
module rational_arithmetic_unit #(
	parameter int DATA_WIDTH = rau_pkg::DataWidthDefault
) (
	input logic clk,
	input logic arst_n,
	rau_in_if.sink in_ch,
	rau_out_if.source out_ch
);
	import rau_pkg::*;

	logic q_valid, q_ready;
	op_t q_op;
	logic [4*DATA_WIDTH-1:0] q_data;

	rau_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.clk, .arst_n, .in_ch, .q_valid, .q_ready, .q_op, .q_data
	);

	rau_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_op, .q_data, .out_ch
	);
endmodule

// File: bench/rational_arithmetic_unit_checker.sv
`timescale 1ns / 1ps
module rational_arithmetic_unit_checker (
	input logic clk,
	input logic arst_n,
	rau_in_if in_ch,
	rau_out_if out_ch,
	output int fail_count,
	output int pending,
	output int results_seen
);
	import rau_pkg::*;

	typedef struct packed {
		logic signed [32:0] num;
		logic signed [32:0] den;
		logic status;
	} fraction_t;

	fraction_t expected_fractions[$];

	function automatic fraction_t compute_fraction(logic [1:0] op, logic signed [15:0] an,
			logic signed [15:0] ad, logic signed [15:0] bn, logic signed [15:0] bd);
		fraction_t r;
		longint p, q, x, y, t, g, mn, md;
		p = longint'(an) * longint'(bd);
		q = longint'(bn) * longint'(ad);
		r.status = 1'b0;
		case (op_t'(op))
			OP_ADD: begin
				r.num = 33'(p + q);
				r.den = 33'(longint'(ad) * longint'(bd));
			end
			OP_SUB: begin
				r.num = 33'(p - q);
				r.den = 33'(longint'(ad) * longint'(bd));
			end
			OP_DIV: begin
				r.num = 33'(p);
				r.den = 33'(longint'(ad) * longint'(bn));
			end
			default: begin
				mn = (an < 0) ? -longint'(an) : longint'(an);
				md = (ad < 0) ? -longint'(ad) : longint'(ad);
				x = mn;
				y = md;
				while (y != 0) begin
					t = x % y;
					x = y;
					y = t;
				end
				g = x;
				if (g == 0) begin
					r.num = 33'(an);
					r.den = 33'(ad);
					r.status = 1'b1;
				end else begin
					r.num = 33'((an < 0) ? -(mn / g) : mn / g);
					r.den = 33'((ad < 0) ? -(md / g) : md / g);
				end
			end
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fraction_t e;
		if (!arst_n) begin
			fail_count <= 0;
			results_seen <= 0;
			pending <= 0;
			expected_fractions.delete();
		end else begin
			if (in_ch.valid && in_ch.ready)
				expected_fractions.push_back(compute_fraction(in_ch.op, in_ch.a_num,
					in_ch.a_den, in_ch.b_num, in_ch.b_den));
			if (out_ch.valid && out_ch.ready) begin
				results_seen <= results_seen + 1;
				if (expected_fractions.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result %0d/%0d status %0b", out_ch.res_num,
							out_ch.res_den, out_ch.status);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_fractions.pop_front();
					if (e.num !== out_ch.res_num || e.den !== out_ch.res_den
							|| e.status !== out_ch.status) begin
						if (fail_count < 10)
							$display("mismatch: expected %0d/%0d st %0b, got %0d/%0d st %0b",
								e.num, e.den, e.status, out_ch.res_num, out_ch.res_den,
								out_ch.status);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= expected_fractions.size();
		end
	end
endmodule

// File: bench/rational_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
module rational_arithmetic_unit_tb;
	import rau_pkg::*;

	localparam int RandomItems = 650;
	localparam int WatchdogLimit = 20000;

	logic clk;
	logic arst_n;
	int fail_count, pending, results_seen, items_sent, idle_cycles;
	int op_counts[4];
	bit long_hold;

	rau_in_if in_ch ();
	rau_out_if out_ch ();

	rational_arithmetic_unit DUT (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));

	rational_arithmetic_unit_checker checker_i (.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.out_ch(out_ch), .fail_count(fail_count), .pending(pending),
		.results_seen(results_seen));

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic send_item(op_t op, logic [15:0] an, logic [15:0] ad, logic [15:0] bn,
			logic [15:0] bd);
		int gap;
		gap = $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		repeat (gap) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.op <= op;
		in_ch.a_num <= an;
		in_ch.a_den <= ad;
		in_ch.b_num <= bn;
		in_ch.b_den <= bd;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		op_counts[op]++;
		items_sent++;
	endtask

	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'($signed($urandom_range(0, 40)) - 20);
			3: return 16'($urandom_range(1, 12) * 12);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		int gap;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				repeat (60) @(posedge clk);
				long_hold = 1'b0;
			end
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 5);
			out_ch.ready <= 1'b0;
			repeat (gap) @(posedge clk);
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid)
				@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("watchdog: no transfer for %0d cycles", WatchdogLimit);
			$display("** rational_arithmetic_unit: FAILED **");
			$finish;
		end
	end

	initial begin
		logic [15:0] corner[6];
		corner = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h5555};
		in_ch.valid = 1'b0;
		in_ch.op = OP_ADD;
		in_ch.a_num = '0;
		in_ch.a_den = '0;
		in_ch.b_num = '0;
		in_ch.b_den = '0;
		arst_n = 1'b0;
		idle_cycles = 0;
		items_sent = 0;
		long_hold = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < 4; i++)
			send_item(op_t'(i), corner[i % 6], corner[(i + 1) % 6], corner[(i + 2) % 6],
				corner[(i + 3) % 6]);
		send_item(OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_item(OP_SUB, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
		send_item(OP_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
		send_item(OP_ADD, 16'd3, 16'd0, 16'd5, 16'd0);
		send_item(OP_DIV, 16'd3, 16'd4, 16'd0, 16'd7);
		send_item(OP_SIMP, 16'd0, 16'd0, 16'hffff, 16'hffff);
		send_item(OP_SIMP, 16'd0, 16'hfff6, 16'd0, 16'd0);
		send_item(OP_SIMP, 16'hff9c, 16'd0, 16'd0, 16'd0);
		send_item(OP_SIMP, 16'h8000, 16'h8000, 16'd0, 16'd0);
		send_item(OP_SIMP, 16'h8000, 16'h7fff, 16'd0, 16'd0);
		send_item(OP_SIMP, 16'hffd0, 16'd36, 16'd0, 16'd0);
		send_item(OP_SIMP, 16'd6765, 16'd10946, 16'd0, 16'd0);
		send_item(OP_SIMP, 16'h8000, 16'hc000, 16'd0, 16'd0);
		send_item(OP_SUB, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
		in_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);

		for (int i = 0; i < RandomItems; i++) begin
			if (i == 100)
				long_hold = 1'b1;
			if (i == 300) begin
				in_ch.valid <= 1'b0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
			send_item(op_t'($urandom_range(0, 3)), pick_value(), pick_value(), pick_value(),
				pick_value());
		end
		in_ch.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		$display("covered %0d items: add %0d, sub %0d, div %0d, simplify %0d; %0d results",
			items_sent, op_counts[0], op_counts[1], op_counts[2], op_counts[3], results_seen);
		if (fail_count == 0 && pending == 0)
			$display("** rational_arithmetic_unit: PASSED **");
		else
			$display("** rational_arithmetic_unit: FAILED **");
		$finish;
	end
endmodule
